// ===== sv/pdod_pkg.sv =====
// ----------------------------------------------------------------------------
// pdod_pkg
// Shared types and constants of the pressure door-open detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pdod_pkg;

    localparam int PRESS_W = 21;
    localparam int HUM_W   = 17;
    localparam int BAND_W  = 14;
    localparam int STEP_W  = 17;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 21;

    localparam logic [PRESS_W-1:0] FAULT_HIGH    = 21'd1100000;
    localparam logic [PRESS_W-1:0] FAULT_LOW     = 21'd1000;
    localparam logic [HUM_W-1:0]   HUMIDITY_FULL = 17'd100000;

    localparam logic [BAND_W-1:0]  OPEN_MARGIN_RST   = 14'd230;
    localparam logic [BAND_W-1:0]  SETTLE_LOWER_RST  = 14'd80;
    localparam logic [BAND_W-1:0]  SETTLE_UPPER_RST  = 14'd100;
    localparam logic [STEP_W-1:0]  MAX_STEP_RST      = 17'd2000;
    localparam logic [PRESS_W-1:0] PLAUS_MIN_RST     = 21'd800000;
    localparam logic [PRESS_W-1:0] PLAUS_MAX_RST     = 21'd1000000;

    typedef enum logic [CIDX_W-1:0] {
        REG_OPEN_MARGIN   = 3'd0,
        REG_SETTLE_LOWER  = 3'd1,
        REG_SETTLE_UPPER  = 3'd2,
        REG_MAX_STEP      = 3'd3,
        REG_PLAUS_MIN     = 3'd4,
        REG_PLAUS_MAX     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic               door_open;
        logic [PRESS_W-1:0] closed_avg;
        logic [PRESS_W-1:0] open_avg;
    } track_t;

    typedef struct packed {
        logic               sample_accepted;
        logic               sensor_fault;
        track_t             track;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/pdod_window.sv =====
// ----------------------------------------------------------------------------
// pdod_window
// Moving sample window with running sum; gives the window average that
// results from the sample being pushed in this cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdod_window #(
    parameter int DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic                         first,
    input  wire logic [pdod_pkg::PRESS_W-1:0] sample,
    output logic      [pdod_pkg::PRESS_W-1:0] avg
);

    localparam int PW    = pdod_pkg::PRESS_W;
    localparam int LOG_D = $clog2(DEPTH);
    localparam int SUM_W = PW + LOG_D;
    localparam int SHIFT = SUM_W + LOG_D;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

    logic [PW-1:0]    window_reg [DEPTH];
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [2*SUM_W:0] prod;

    always_comb
    begin
        if (first)
        begin
            sum_next = SUM_W'({{LOG_D{1'b0}}, sample} * SUM_W'(DEPTH));
        end
        else
        begin
            sum_next = sum_reg - SUM_W'(window_reg[0]) + SUM_W'(sample);
        end
    end

    // floor(sum / DEPTH) by exact reciprocal multiply
    assign prod = {{(SUM_W+1){1'b0}}, sum_next} * {{SUM_W{1'b0}}, RECIP};
    assign avg  = prod[SHIFT +: PW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (push)
        begin
            sum_reg <= sum_next;
        end
    end

    // taps; the first sample fills every slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (first || i == DEPTH - 1)
                begin
                    window_reg[i] <= sample;
                end
                else
                begin
                    window_reg[i] <= window_reg[i+1];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/pdod_track.sv =====
// ----------------------------------------------------------------------------
// pdod_track
// Closed/open door averages and the strike counter that drives the door flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pdod_track #(
    parameter int DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         update,
    input  wire logic [pdod_pkg::PRESS_W-1:0] sample,
    input  wire logic [pdod_pkg::PRESS_W-1:0] avg,
    input  wire logic [pdod_pkg::BAND_W-1:0]  open_margin,
    input  wire logic [pdod_pkg::BAND_W-1:0]  settle_lower,
    input  wire logic [pdod_pkg::BAND_W-1:0]  settle_upper,
    output pdod_pkg::track_t                  after
);

    localparam int PW    = pdod_pkg::PRESS_W;
    localparam int DW    = PW + 2;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    logic [PW-1:0]    closed_reg, closed_next, closed_upd;
    logic [PW-1:0]    open_reg, open_next, open_upd;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             flag_reg, flag_next;

    logic signed [DW-1:0] d, e, d2, e2;
    logic signed [DW-1:0] sl, su, om;
    logic                 settled, strike;

    always_comb
    begin
        sl = $signed({{(DW-pdod_pkg::BAND_W){1'b0}}, settle_lower});
        su = $signed({{(DW-pdod_pkg::BAND_W){1'b0}}, settle_upper});
        om = $signed({{(DW-pdod_pkg::BAND_W){1'b0}}, open_margin});
        d  = $signed({2'b00, closed_reg}) - $signed({2'b00, sample});
        e  = $signed({2'b00, open_reg}) - $signed({2'b00, sample});

        settled = (flag_reg && cnt_reg == CNT_MAX) || (!flag_reg && cnt_reg == '0);

        closed_upd = closed_reg;
        open_upd   = open_reg;
        if (settled)
        begin
            if (closed_reg == '0 || (d > -sl && d < su && !flag_reg))
            begin
                closed_upd = avg;
            end
            else if (flag_reg && (open_reg == '0 || (e > -su && e < sl)))
            begin
                open_upd = avg;
            end
        end

        // strike test sees the averages just updated
        d2 = $signed({2'b00, closed_upd}) - $signed({2'b00, sample});
        e2 = $signed({2'b00, open_upd}) - $signed({2'b00, sample});
        strike = (d2 < -om) || (open_upd != '0 && e2 < om);

        cnt_next    = cnt_reg;
        flag_next   = flag_reg;
        open_next   = open_upd;
        closed_next = closed_upd;
        if (strike)
        begin
            if (cnt_reg >= CNT_MAX)
            begin
                flag_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else
        begin
            if (cnt_reg == '0)
            begin
                flag_next = 1'b0;
                open_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end

        // hold state when the sample does not update
        if (!update)
        begin
            cnt_next    = cnt_reg;
            flag_next   = flag_reg;
            open_next   = open_reg;
            closed_next = closed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= '0;
            open_reg   <= '0;
            cnt_reg    <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            closed_reg <= closed_next;
            open_reg   <= open_next;
            cnt_reg    <= cnt_next;
            flag_reg   <= flag_next;
        end
    end

    assign after.door_open  = flag_next;
    assign after.closed_avg = closed_next;
    assign after.open_avg   = open_next;

endmodule

`default_nettype wire

// ===== sv/pressure_door_open_detector.sv =====
// ----------------------------------------------------------------------------
// pressure_door_open_detector
// Door-open detection from a stream of pressure and humidity samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one pressure_sample and
//   humidity_sample per beat. Output channel (out_valid / out_stall) returns
//   exactly one result beat per input beat, in order.
//   Result: each result is registered into the output buffer as its input beat is taken.
//   Throughput: one beat per cycle while in_stall is low; the whole update (fault test, window
//   push, reciprocal-multiply average, band compares, strike counter) sits
//   between the state registers and a two-entry output buffer.
//   Stall: when the receiver stalls, results collect in the output buffer;
//   in_stall rises only once both entries are full, and drops as soon as
//   the receiver takes a beat.
//   Configuration: cfg_valid / cfg_ready write register cfg_index with
//   cfg_data; cfg_ready is always high, unknown indexes are dropped.
//   Write it only while the block is idle.
//   Reset (rst_n low, asynchronous) restores register defaults, clears the
//   window sum and averages, the door flag and the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_door_open_detector #(
    parameter int WINDOW_DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [pdod_pkg::PRESS_W-1:0] pressure_sample,
    input  wire logic [pdod_pkg::HUM_W-1:0]   humidity_sample,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              sample_accepted,
    output logic                              sensor_fault,
    output logic                              door_open,
    output logic      [pdod_pkg::PRESS_W-1:0] closed_average,
    output logic      [pdod_pkg::PRESS_W-1:0] open_average_out,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [pdod_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [pdod_pkg::CDATA_W-1:0] cfg_data
);

    localparam int PW = pdod_pkg::PRESS_W;

    logic [pdod_pkg::BAND_W-1:0] open_margin_reg, settle_lower_reg, settle_upper_reg;
    logic [pdod_pkg::STEP_W-1:0] max_step_reg;
    logic [PW-1:0]               plaus_min_reg, plaus_max_reg;
    logic [PW-1:0]               last_reg;

    logic             in_take, out_take;
    logic             fault, plausible, ok, first, update;
    logic [PW-1:0]    step, avg;
    pdod_pkg::track_t after;
    pdod_pkg::result_t res_new, main_reg, skid_reg;
    logic             main_valid_reg, skid_valid_reg;

    // ---------------- configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_margin_reg  <= pdod_pkg::OPEN_MARGIN_RST;
            settle_lower_reg <= pdod_pkg::SETTLE_LOWER_RST;
            settle_upper_reg <= pdod_pkg::SETTLE_UPPER_RST;
            max_step_reg     <= pdod_pkg::MAX_STEP_RST;
            plaus_min_reg    <= pdod_pkg::PLAUS_MIN_RST;
            plaus_max_reg    <= pdod_pkg::PLAUS_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (pdod_pkg::cfg_index_t'(cfg_index))
                pdod_pkg::REG_OPEN_MARGIN:  open_margin_reg  <= cfg_data[pdod_pkg::BAND_W-1:0];
                pdod_pkg::REG_SETTLE_LOWER: settle_lower_reg <= cfg_data[pdod_pkg::BAND_W-1:0];
                pdod_pkg::REG_SETTLE_UPPER: settle_upper_reg <= cfg_data[pdod_pkg::BAND_W-1:0];
                pdod_pkg::REG_MAX_STEP:     max_step_reg     <= cfg_data[pdod_pkg::STEP_W-1:0];
                pdod_pkg::REG_PLAUS_MIN:    plaus_min_reg    <= cfg_data;
                pdod_pkg::REG_PLAUS_MAX:    plaus_max_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- sample checks
    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !in_stall;
    assign out_take = main_valid_reg && !out_stall;

    assign first = (last_reg == '0);
    assign fault = (pressure_sample == pdod_pkg::FAULT_HIGH) ||
                   (pressure_sample < pdod_pkg::FAULT_LOW);
    assign step  = (last_reg > pressure_sample) ? last_reg - pressure_sample
                                                : pressure_sample - last_reg;
    assign plausible = first ||
                       (step < PW'(max_step_reg) &&
                        pressure_sample > plaus_min_reg &&
                        pressure_sample < plaus_max_reg &&
                        humidity_sample != pdod_pkg::HUMIDITY_FULL);
    assign ok     = !fault && plausible;
    assign update = in_take && ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (update)
        begin
            last_reg <= pressure_sample;
        end
    end

    pdod_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (update),
        .first  (first),
        .sample (pressure_sample),
        .avg    (avg)
    );

    pdod_track #(
        .DEPTH (WINDOW_DEPTH)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (update),
        .sample       (pressure_sample),
        .avg          (avg),
        .open_margin  (open_margin_reg),
        .settle_lower (settle_lower_reg),
        .settle_upper (settle_upper_reg),
        .after        (after)
    );

    assign res_new.sample_accepted = ok;
    assign res_new.sensor_fault    = fault;
    assign res_new.track           = after;

    // ---------------- two-entry output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take)
        begin
            if (main_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (in_take)
        begin
            if (main_valid_reg && !out_take)
            begin
                skid_reg <= res_new;
            end
            else
            begin
                main_reg <= res_new;
            end
        end
    end

    assign out_valid        = main_valid_reg;
    assign sample_accepted  = main_reg.sample_accepted;
    assign sensor_fault     = main_reg.sensor_fault;
    assign door_open        = main_reg.track.door_open;
    assign closed_average   = main_reg.track.closed_avg;
    assign open_average_out = main_reg.track.open_avg;

    // ---------------- assertions
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid entry held while output register empty");

    a_fault_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(sample_accepted && sensor_fault))
        else $error("faulty sample reported as accepted");

    a_open_needs_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && door_open) |-> (closed_average != '0))
        else $error("door open with no closed-door average");

    a_open_avg_only_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !door_open) |-> (open_average_out == '0))
        else $error("open-door average kept while door closed");

endmodule

`default_nettype wire

// ===== verif/pressure_door_open_detector_test.sv =====
// ----------------------------------------------------------------------------
// pressure_door_open_detector_test
// Self-checking bench for the door-open detector. Sample beats go in with
// random gaps while the result side stalls at random. A behavioral tracker
// predicts every result beat, covering the window, both averages, the strike
// counter and the door flag, and each beat is compared field by field. The
// run steps through several register settings, extremes included.
// ----------------------------------------------------------------------------
module pressure_door_open_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRESS_W = pdod_pkg::PRESS_W;
    localparam int HUM_W   = pdod_pkg::HUM_W;
    localparam int BAND_W  = pdod_pkg::BAND_W;
    localparam int STEP_W  = pdod_pkg::STEP_W;
    localparam int CIDX_W  = pdod_pkg::CIDX_W;
    localparam int CDATA_W = pdod_pkg::CDATA_W;
    localparam int TOTAL_W = PRESS_W + 5;

    localparam logic [PRESS_W-1:0] FAULT_HIGH    = pdod_pkg::FAULT_HIGH;
    localparam logic [PRESS_W-1:0] FAULT_LOW     = pdod_pkg::FAULT_LOW;
    localparam logic [HUM_W-1:0]   HUMIDITY_FULL = pdod_pkg::HUMIDITY_FULL;

    localparam int WINDOW = 16;
    localparam int SENDER = 0;
    localparam int RECEIVER = 1;

    // indexes with no register behind them
    localparam logic [CIDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [PRESS_W-1:0] PRESS_ALL_ONES = '1;
    localparam logic [HUM_W-1:0]   HUM_ALL_ONES   = '1;
    localparam logic [CDATA_W-1:0] DATA_ALL_ONES  = '1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [PRESS_W-1:0]  pressure_sample = '0;
    logic [HUM_W-1:0]    humidity_sample = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                sample_accepted;
    logic                sensor_fault;
    logic                door_open;
    logic [PRESS_W-1:0]  closed_average;
    logic [PRESS_W-1:0]  open_average_out;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CDATA_W-1:0]  cfg_data = '0;

    // tracker state
    logic [PRESS_W-1:0]  window_m [WINDOW];
    logic [TOTAL_W-1:0]  window_total = '0;
    logic [PRESS_W-1:0]  closed_level = '0;
    logic [PRESS_W-1:0]  open_level = '0;
    logic [PRESS_W-1:0]  prev_press = '0;
    int unsigned         strikes = 0;
    logic                door_flag = 1'b0;

    // tracker copy of the registers
    logic [BAND_W-1:0]   margin_r = pdod_pkg::OPEN_MARGIN_RST;
    logic [BAND_W-1:0]   settle_lo_r = pdod_pkg::SETTLE_LOWER_RST;
    logic [BAND_W-1:0]   settle_hi_r = pdod_pkg::SETTLE_UPPER_RST;
    logic [STEP_W-1:0]   step_r = pdod_pkg::MAX_STEP_RST;
    logic [PRESS_W-1:0]  band_min_r = pdod_pkg::PLAUS_MIN_RST;
    logic [PRESS_W-1:0]  band_max_r = pdod_pkg::PLAUS_MAX_RST;

    pdod_pkg::result_t   expected_results [$];
    int unsigned         mismatches = 0;
    int unsigned         samples_sent = 0;
    int                  calm [2] = '{0, 0};
    logic [PRESS_W-1:0]  rest_level = '0;

    pressure_door_open_detector #(
        .WINDOW_DEPTH(WINDOW)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pressure_sample(pressure_sample),
        .humidity_sample(humidity_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_accepted(sample_accepted),
        .sensor_fault(sensor_fault),
        .door_open(door_open),
        .closed_average(closed_average),
        .open_average_out(open_average_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(input int side);
        if (calm[side] > 0)
        begin
            calm[side]--;
            return 0;
        end
        // now and then run a stretch with no idle cycles at all
        if ($urandom_range(0, 19) == 0)
        begin
            calm[side] = int'($urandom_range(10, 40));
            return 0;
        end
        return int'($urandom_range(0, 13));
    endfunction

    function automatic void report_mismatch(input string what, input longint want,
                                            input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function automatic void load_register(input logic [CIDX_W-1:0] idx,
                                          input logic [CDATA_W-1:0] value);
        case (idx)
            pdod_pkg::REG_OPEN_MARGIN:  margin_r = value[BAND_W-1:0];
            pdod_pkg::REG_SETTLE_LOWER: settle_lo_r = value[BAND_W-1:0];
            pdod_pkg::REG_SETTLE_UPPER: settle_hi_r = value[BAND_W-1:0];
            pdod_pkg::REG_MAX_STEP:     step_r = value[STEP_W-1:0];
            pdod_pkg::REG_PLAUS_MIN:    band_min_r = value[PRESS_W-1:0];
            pdod_pkg::REG_PLAUS_MAX:    band_max_r = value[PRESS_W-1:0];
            default:                    ;
        endcase
    endfunction

    // Advance the door tracker by one sample and return the result beat it causes.
    function automatic pdod_pkg::result_t predict_door_state(input logic [PRESS_W-1:0] p,
                                                             input logic [HUM_W-1:0] h);
        pdod_pkg::result_t  r;
        logic [PRESS_W-1:0] jump;
        logic [PRESS_W-1:0] mean;
        longint             d;
        longint             e;
        bit                 take;
        bit                 strike;
        r = '0;
        if (p == FAULT_HIGH || p < FAULT_LOW)
        begin
            r.sensor_fault = 1'b1;
        end
        else
        begin
            jump = (prev_press > p) ? prev_press - p : p - prev_press;
            take = (prev_press == '0) ||
                   (jump < PRESS_W'(step_r) && p > band_min_r && p < band_max_r &&
                    h != HUMIDITY_FULL);
            if (take)
            begin
                r.sample_accepted = 1'b1;
                if (prev_press == '0)
                begin
                    // first sample primes the whole window
                    foreach (window_m[i])
                        window_m[i] = p;
                    window_total = TOTAL_W'(p * WINDOW);
                end
                else
                begin
                    window_total = window_total - TOTAL_W'(window_m[0]) + TOTAL_W'(p);
                    for (int i = 0; i < WINDOW - 1; i++)
                        window_m[i] = window_m[i + 1];
                    window_m[WINDOW - 1] = p;
                end
                mean = PRESS_W'(window_total / WINDOW);

                d = longint'(closed_level) - longint'(p);
                e = longint'(open_level) - longint'(p);
                if ((door_flag && strikes == WINDOW) || (!door_flag && strikes == 0))
                begin
                    if (closed_level == '0 ||
                        (d > -longint'(settle_lo_r) && d < longint'(settle_hi_r) &&
                         !door_flag))
                        closed_level = mean;
                    else if (door_flag &&
                             (open_level == '0 ||
                              (e > -longint'(settle_hi_r) && e < longint'(settle_lo_r))))
                        open_level = mean;
                end

                d = longint'(closed_level) - longint'(p);
                e = longint'(open_level) - longint'(p);
                strike = d < -longint'(margin_r) ||
                         (open_level != '0 && e < longint'(margin_r));
                if (strike)
                begin
                    if (strikes >= WINDOW)
                        door_flag = 1'b1;
                    else
                        strikes++;
                end
                else if (strikes == 0)
                begin
                    door_flag = 1'b0;
                    open_level = '0;
                end
                else
                    strikes--;
                prev_press = p;
            end
        end
        r.track.door_open = door_flag;
        r.track.closed_avg = closed_level;
        r.track.open_avg = open_level;
        return r;
    endfunction

    // Next pressure heading for target, jittered, kept inside the step limit.
    function automatic logic [PRESS_W-1:0] toward(input longint target, input int jitter);
        longint lim;
        longint delta;
        longint p;
        lim = (step_r > 0) ? longint'(step_r) - 1 : longint'(0);
        delta = target - longint'(prev_press) +
                longint'($urandom_range(0, 2 * jitter)) - longint'(jitter);
        if (delta > lim)
            delta = lim;
        if (delta < -lim)
            delta = -lim;
        p = longint'(prev_press) + delta;
        if (p < longint'(FAULT_LOW))
            p = longint'(FAULT_LOW);
        if (p > longint'(PRESS_ALL_ONES))
            p = longint'(PRESS_ALL_ONES);
        if (p == longint'(FAULT_HIGH))
            p = (delta < 0) ? p + 1 : p - 1;
        return p[PRESS_W-1:0];
    endfunction

    task automatic send_sample(input logic [PRESS_W-1:0] p, input logic [HUM_W-1:0] h);
        int gap;
        gap = draw_wait(SENDER);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pressure_sample <= p;
        humidity_sample <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_door_state(p, h));
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic send_run(input longint target, input int jitter, input int count);
        logic [HUM_W-1:0] h;
        repeat (count)
        begin
            h = ($urandom_range(0, 29) == 0) ? HUMIDITY_FULL
                                             : HUM_W'($urandom_range(0, 99999));
            send_sample(toward(target, jitter), h);
        end
    endtask

    task automatic write_register(input logic [CIDX_W-1:0] idx,
                                  input logic [CDATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        load_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input int margin, input int lo, input int hi,
                                  input int step, input int pmin, input int pmax);
        write_register(pdod_pkg::REG_OPEN_MARGIN, CDATA_W'(margin));
        write_register(pdod_pkg::REG_SETTLE_LOWER, CDATA_W'(lo));
        write_register(pdod_pkg::REG_SETTLE_UPPER, CDATA_W'(hi));
        write_register(pdod_pkg::REG_MAX_STEP, CDATA_W'(step));
        write_register(pdod_pkg::REG_PLAUS_MIN, CDATA_W'(pmin));
        write_register(pdod_pkg::REG_PLAUS_MAX, CDATA_W'(pmax));
    endtask

    // Drop valid and hold until every result beat is back.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Open the plausibility gate wide and walk the last pressure to target.
    task automatic steer_to(input longint target);
        wait_quiet();
        write_register(pdod_pkg::REG_MAX_STEP, DATA_ALL_ONES);
        write_register(pdod_pkg::REG_PLAUS_MIN, '0);
        write_register(pdod_pkg::REG_PLAUS_MAX, DATA_ALL_ONES);
        while (prev_press != target[PRESS_W-1:0])
            send_sample(toward(target, 0), '0);
        rest_level = target[PRESS_W-1:0];
        wait_quiet();
    endtask

    task automatic run_traffic(input int budget);
        int     stop;
        int     choice;
        int     jitter;
        longint level;
        stop = samples_sent + budget;
        while (samples_sent < stop)
        begin
            choice = int'($urandom_range(0, 99));
            jitter = int'($urandom_range(0, (settle_hi_r > 40) ? int'(settle_hi_r) : 40));
            if (choice < 65)
            begin
                // rest, move (mostly past the margin) and hold, then return
                level = longint'(rest_level) + longint'(margin_r) +
                        longint'($urandom_range(1, 800));
                if ($urandom_range(0, 3) == 0)
                    level = longint'(rest_level) + longint'($urandom_range(0, margin_r));
                if ($urandom_range(0, 7) == 0)
                    level = longint'(rest_level) - longint'($urandom_range(1, 3000));
                send_run(rest_level, jitter, int'($urandom_range(2, 20)));
                send_run(level, jitter, int'($urandom_range(8, 40)));
                send_run(rest_level, jitter, int'($urandom_range(8, 40)));
            end
            else if (choice < 80)
            begin
                send_run(longint'($urandom_range(FAULT_LOW, PRESS_ALL_ONES - 1)),
                         int'($urandom_range(0, 20000)), int'($urandom_range(3, 12)));
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(0, 3))
                        0: send_sample(PRESS_W'($urandom_range(0, PRESS_ALL_ONES)),
                                       HUM_W'($urandom_range(0, HUM_ALL_ONES)));
                        1: send_sample(PRESS_W'($urandom_range(0, FAULT_LOW - 1)),
                                       HUM_W'($urandom_range(0, HUM_ALL_ONES)));
                        2: send_sample(FAULT_HIGH, HUM_W'($urandom_range(0, HUM_ALL_ONES)));
                        // step exactly at the limit
                        default: send_sample(prev_press + PRESS_W'(step_r),
                                             HUM_W'($urandom_range(0, 99999)));
                    endcase
                end
            end
        end
    endtask

    task automatic run_phase(input longint target, input int margin, input int lo,
                             input int hi, input int step, input int pmin,
                             input int pmax, input int budget);
        steer_to(target);
        apply_settings(margin, lo, hi, step, pmin, pmax);
        run_traffic(budget);
        wait_quiet();
    endtask

    task automatic test_fault_and_first_sample();
        send_sample('0, '0);
        send_sample(FAULT_LOW - 21'd1, '0);
        send_sample(FAULT_HIGH, HUM_ALL_ONES);
        // first accepted beat fills the window
        send_sample(21'd900000, 17'd50000);
        send_sample(21'd900000, HUMIDITY_FULL);
        send_sample(21'd901999, 17'd99999);
        send_sample(21'd903999, '0);
        send_sample(FAULT_LOW, '0);
        send_sample(FAULT_HIGH + 21'd1, '0);
        send_sample(PRESS_ALL_ONES, HUM_ALL_ONES);
        send_sample(21'd901000, HUM_ALL_ONES);
        wait_quiet();
        write_register(pdod_pkg::REG_PLAUS_MIN, 21'd900000);
        write_register(pdod_pkg::REG_PLAUS_MAX, 21'd902000);
        send_sample(21'd900000, '0);
        send_sample(21'd902000, '0);
        send_sample(21'd900001, '0);
        send_sample(21'd901999, '0);
        wait_quiet();
    endtask

    task automatic test_default_registers();
        steer_to(900000);
        apply_settings(int'(pdod_pkg::OPEN_MARGIN_RST), int'(pdod_pkg::SETTLE_LOWER_RST),
                       int'(pdod_pkg::SETTLE_UPPER_RST), int'(pdod_pkg::MAX_STEP_RST),
                       int'(pdod_pkg::PLAUS_MIN_RST), int'(pdod_pkg::PLAUS_MAX_RST));
        // writes to unused indexes must leave everything alone
        write_register(REG_SPARE_LO, CDATA_W'($urandom_range(0, DATA_ALL_ONES)));
        write_register(REG_SPARE_HI, DATA_ALL_ONES);
        run_traffic(250);
        wait_quiet();
    endtask

    task automatic test_tight_bands();
        run_phase(850000, 0, 0, 0, 2000, 800000, 1000000, 200);
    endtask

    task automatic test_wide_bands();
        run_phase(600000, 10000, 10000, 10000, 100000, 0, 1100000, 200);
    endtask

    task automatic test_full_width_registers();
        run_phase(1500000, 16383, 16383, 16383, 131071, 0, 2097151, 200);
    endtask

    task automatic test_closed_gate();
        // zero step and an inverted band reject everything
        run_phase(900000, 230, 80, 100, 0, 1000000, 800000, 60);
    endtask

    task automatic test_random_registers();
        int target;
        int step;
        repeat (3)
        begin
            target = int'($urandom_range(100000, 1000000));
            step = ($urandom_range(0, 3) == 0) ? int'($urandom_range(2, 500))
                                               : int'($urandom_range(1000, 100000));
            run_phase(target, int'($urandom_range(0, 10000)), int'($urandom_range(0, 10000)),
                      int'($urandom_range(0, 10000)), step,
                      target - int'($urandom_range(1, 100000)),
                      target + int'($urandom_range(1, 100000)), 110);
        end
    endtask

    initial
    begin : main
        int waited;
        waited = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_fault_and_first_sample();
        test_default_registers();
        test_tight_bands();
        test_wide_bands();
        test_full_width_registers();
        test_closed_gate();
        test_random_registers();

        in_valid <= 1'b0;
        while (expected_results.size() != 0 && waited < 1000)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
            report_mismatch("missing result beats", 0, expected_results.size());
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : receiver
        int hold;
        @(negedge clk);
        forever
        begin
            hold = draw_wait(RECEIVER);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        pdod_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result beat", 0, 1);
            else
            begin
                want = expected_results.pop_front();
                if (sample_accepted !== want.sample_accepted)
                    report_mismatch("sample_accepted", want.sample_accepted, sample_accepted);
                if (sensor_fault !== want.sensor_fault)
                    report_mismatch("sensor_fault", want.sensor_fault, sensor_fault);
                if (door_open !== want.track.door_open)
                    report_mismatch("door_open", want.track.door_open, door_open);
                if (closed_average !== want.track.closed_avg)
                    report_mismatch("closed_average", want.track.closed_avg, closed_average);
                if (open_average_out !== want.track.open_avg)
                    report_mismatch("open_average_out", want.track.open_avg,
                                    open_average_out);
            end
        end
    end

    initial
    begin : watchdog
        // far beyond the slowest legal run
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== pressure_door_open_detector.f =====
sv/pdod_pkg.sv
sv/pdod_window.sv
sv/pdod_track.sv
sv/pressure_door_open_detector.sv
verif/pressure_door_open_detector_test.sv
